FILE: sv/async_hdlc_deframer_fcs_check_unit_assert.svh
// Assertion macros for the asynchronous HDLC receive deframer.
// Depends on signals named clk and rst in the module that includes this header.
`ifndef ASYNC_HDLC_DEFRAMER_FCS_CHECK_UNIT_ASSERT_SVH
`define ASYNC_HDLC_DEFRAMER_FCS_CHECK_UNIT_ASSERT_SVH
`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define AHDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must never be true outside reset.
`define AHDF_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define AHDF_ASSERT(label, prop, msg)
`define AHDF_ASSERT_NEVER(label, expr, msg)
`endif
`endif

FILE: sv/ahdf_pkg.sv
// Shared constants and helper functions for the asynchronous HDLC deframer.
// No dependencies.
`default_nettype none
package ahdf_pkg;

  localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] FCS_INIT   = 16'hFFFF;
  localparam logic [15:0] FCS_GOOD   = 16'hF0B8;
  localparam logic [15:0] FCS_POLY   = 16'h8408;
  localparam logic [15:0] PARITY_MAP = 16'h6996;
  localparam logic [15:0] MRU_RESET  = 16'd1500;
  // Header and FCS bytes allowed beyond the receive unit.
  localparam logic [16:0] MRU_SLACK  = 17'd6;

  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_HANGUP = 1'b1;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [2:0] ST_GOOD    = 3'd0;
  localparam logic [2:0] ST_BAD_FCS = 3'd1;
  localparam logic [2:0] ST_ABORTED = 3'd2;
  localparam logic [2:0] ST_FLUSHED = 3'd3;
  localparam logic [2:0] ST_SHORT   = 3'd4;

  localparam int OUT_W = 32;

  // One byte through the reflected CRC-16, bit at a time.
  function automatic logic [15:0] fcs16_byte(input logic [15:0] fcs, input logic [7:0] c);
    logic [15:0] f;
    f = fcs ^ {8'h00, c};
    for (int i = 0; i < 8; i++) begin
      f = f[0] ? ((f >> 1) ^ FCS_POLY) : (f >> 1);
    end
    return f;
  endfunction

  // Sticky line flags raised by one raw byte.
  function automatic logic [3:0] line_bits(input logic [7:0] c);
    logic [3:0] b;
    b = 4'b0000;
    if (c[7]) begin
      b[0] = 1'b1;
    end else begin
      b[1] = 1'b1;
    end
    if (PARITY_MAP[c[7:4] ^ c[3:0]]) begin
      b[2] = 1'b1;
    end else begin
      b[3] = 1'b1;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: sv/async_hdlc_deframer_fcs_check_unit.sv
// Asynchronous HDLC receive deframer: octet unstuffing, FCS-16 check, frame status.
// Depends on ahdf_pkg and async_hdlc_deframer_fcs_check_unit_assert.svh.
//
// The block takes one line byte or hangup event per cycle and gives at most one result
// per transaction: a payload byte, or an end-of-frame status at a flag byte. The byte is
// captured in an input register, decoded in one pass of logic (escape handling, FCS
// update, length check, two-byte hold-back) and placed in a result register; a new
// item is accepted every cycle unless the input register holds an item while the
// result register is full and not being taken. The last two decoded bytes of each
// frame are the FCS and are never passed on. The receive unit limit may be written
// at any time the block is idle; it takes effect on the next byte.
`default_nettype none
`include "async_hdlc_deframer_fcs_check_unit_assert.svh"
module async_hdlc_deframer_fcs_check_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [15:0]                 cfg_wr_data,   // max_receive_unit
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // rx_byte
  input  wire logic                        s_axis_tuser,  // cmd
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [7:0] data_out, [10:8] end_status, [27:11] frame_length, [31:28] line_flags
  output      logic [ahdf_pkg::OUT_W-1:0]  m_axis_tdata,
  output      logic                        m_axis_tuser   // kind
);
  import ahdf_pkg::*;

  logic        max_receive_unit;
  logic [15:0] mru;
  logic        in_valid;
  logic        in_cmd;
  logic [7:0]  in_byte;
  logic        advance;

  logic [15:0] fcs_acc, fcs_acc_next;
  logic [16:0] byte_count, byte_count_next;
  logic        escape_pending, escape_pending_next;
  logic        flushing, flushing_next;
  logic [7:0]  held0, held1;
  logic [3:0]  seen_flags, seen_flags_next;

  logic        shift;
  logic        proceed;
  logic [7:0]  dec_byte;
  logic [16:0] limit;
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_data;
  logic [2:0]  res_status;
  logic [16:0] res_len;

  assign max_receive_unit = cfg_wr_en;
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign limit         = {1'b0, mru} + MRU_SLACK;

  always_ff @(posedge clk) begin
    if (rst) begin
      mru <= MRU_RESET;
    end else if (max_receive_unit) begin
      mru <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd  <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  always_comb begin
    fcs_acc_next        = fcs_acc;
    byte_count_next     = byte_count;
    escape_pending_next = escape_pending;
    flushing_next       = flushing;
    seen_flags_next     = seen_flags;
    shift               = 1'b0;
    proceed             = 1'b0;
    dec_byte            = in_byte;
    res_valid           = 1'b0;
    res_kind            = KIND_DATA;
    res_data            = 8'h00;
    res_status          = ST_GOOD;
    res_len             = 17'd0;
    if (in_cmd == CMD_HANGUP) begin
      byte_count_next     = 17'd0;
      fcs_acc_next        = FCS_INIT;
      flushing_next       = 1'b1;
      escape_pending_next = 1'b0;
      seen_flags_next     = 4'b0000;
    end else begin
      seen_flags_next = seen_flags | line_bits(in_byte);
      if (in_byte == FLAG_BYTE) begin
        byte_count_next     = 17'd0;
        fcs_acc_next        = FCS_INIT;
        escape_pending_next = 1'b0;
        flushing_next       = 1'b0;
        // An empty frame between back-to-back flags reports nothing.
        if (byte_count != 17'd0 || flushing) begin
          res_valid = 1'b1;
          res_kind  = KIND_END;
          priority if (flushing) begin
            res_status = ST_FLUSHED;
          end else if (escape_pending) begin
            res_status = ST_ABORTED;
          end else if (byte_count <= 17'd2) begin
            res_status = ST_SHORT;
          end else if (fcs_acc == FCS_GOOD) begin
            res_status = ST_GOOD;
          end else begin
            res_status = ST_BAD_FCS;
          end
          res_len = (byte_count >= 17'd2) ? byte_count - 17'd2 : 17'd0;
        end
      end else if (!flushing) begin
        if (escape_pending) begin
          dec_byte            = in_byte ^ ESC_XOR;
          escape_pending_next = 1'b0;
          proceed             = 1'b1;
        end else if (in_byte == ESC_BYTE) begin
          escape_pending_next = 1'b1;
        end else begin
          proceed = 1'b1;
        end
        if (proceed) begin
          if (byte_count >= limit) begin
            flushing_next = 1'b1;
          end else begin
            fcs_acc_next    = fcs16_byte((byte_count == 17'd0) ? FCS_INIT : fcs_acc, dec_byte);
            byte_count_next = byte_count + 17'd1;
            shift           = 1'b1;
            // The two newest bytes may be the FCS, so the oldest held byte goes out.
            if (byte_count >= 17'd2) begin
              res_valid = 1'b1;
              res_data  = held0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fcs_acc        <= FCS_INIT;
      byte_count     <= 17'd0;
      escape_pending <= 1'b0;
      flushing       <= 1'b0;
      seen_flags     <= 4'b0000;
    end else if (advance) begin
      fcs_acc        <= fcs_acc_next;
      byte_count     <= byte_count_next;
      escape_pending <= escape_pending_next;
      flushing       <= flushing_next;
      seen_flags     <= seen_flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && shift) begin
      held0 <= held1;
      held1 <= dec_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_axis_tuser <= res_kind;
      m_axis_tdata <= {seen_flags_next, res_len, res_status, res_data};
    end
  end

  `AHDF_ASSERT(hangup_sets_flush,
    (advance && in_cmd == CMD_HANGUP) |=> flushing,
    "hangup did not set flushing")
  `AHDF_ASSERT_NEVER(esc_while_flush, escape_pending && flushing,
    "escape pending while flushing")
  `AHDF_ASSERT(good_has_length,
    (m_axis_tvalid && m_axis_tuser == KIND_END && m_axis_tdata[10:8] == ST_GOOD)
      |-> (m_axis_tdata[27:11] != 17'd0),
    "good frame with zero length")
  `AHDF_ASSERT(stall_holds_input, (in_valid && !advance) |=> in_valid,
    "input register dropped a stalled item")

endmodule
`default_nettype wire
